/* hw/rtl/tcl_pkg.sv */
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants for the track cache lookup block: result status
// codes, track geometry and the control/status structs of the scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

  // track geometry: 256 sectors per track
  localparam int unsigned SectorBits   = 8;
  localparam int unsigned TrackBits    = 24;
  localparam int unsigned BlockBits    = 32;
  localparam int unsigned StampBits    = 32;
  localparam int unsigned FillBits     = 9;
  localparam logic [BlockBits-1:0] TrackSectors = 32'h0000_0100;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_WB_FAIL = 2'd1,
    ST_FL_FAIL = 2'd2,
    ST_BEYOND  = 2'd3
  } status_t;

  // sequencer to scan unit
  typedef struct packed {
    logic clear;      // start of a new scan
    logic entry_vld;  // slot entry on the inputs this cycle
  } scan_ctl_t;

  // scan unit to sequencer
  typedef struct packed {
    logic hit_found;    // a valid slot holds the requested track
    logic empty_found;  // at least one empty slot was seen
  } scan_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/track_cache_lru_lookup.sv */
// ----------------------------------------------------------------------------
// track_cache_lru_lookup
// Fully associative track cache lookup with LRU replacement by access
// stamps. Slot tracks and stamps live in RAM and are scanned one slot per
// cycle by a shared compare unit under a small sequencer.
//
//   channel   handshake               fields
//   -------   ---------------------   -----------------------------------
//   request   start / busy            block, writeback_ok, fill_ok
//   result    done (one-cycle beat)   status, hit, slot, sector_in_track,
//                                     writeback, victim_track, fill,
//                                     fill_sectors
//   config    cfg_valid / cfg_ready   cfg_data (image_blocks)
//
// A request passes the bound check, the slot scan through the track/stamp
// RAM read port at one slot per cycle and the decision step before the next
// accept; a block beyond the image returns from the bound check.
// Stamp wrap clearing uses per-slot fresh bits, so no RAM sweep is needed
// and the block is ready right after reset.
// Reset is synchronous and active high; image_blocks resets to 1.
// The result beat cannot be stalled; the next request may be accepted in
// the same cycle as the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module track_cache_lru_lookup #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [tcl_pkg::BlockBits-1:0]     block,
  input  wire logic                              writeback_ok,
  input  wire logic                              fill_ok,
  // result
  output logic                                   done,
  output logic      [1:0]                        status,
  output logic                                   hit,
  output logic      [3:0]                        slot,
  output logic      [tcl_pkg::SectorBits-1:0]    sector_in_track,
  output logic                                   writeback,
  output logic      [tcl_pkg::TrackBits-1:0]     victim_track,
  output logic                                   fill,
  output logic      [tcl_pkg::FillBits-1:0]      fill_sectors,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tcl_pkg::BlockBits-1:0]     cfg_data
);

  import tcl_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam logic [CntW-1:0] SlotCnt = CntW'(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t                 state;
  logic [BlockBits-1:0]   image_blocks;
  logic [StampBits-1:0]   access_counter;
  logic [StampBits-1:0]   access_counter_next;
  logic [SLOTS-1:0]       slot_valid;
  logic [SLOTS-1:0]       slot_fresh;

  // latched request
  logic [BlockBits-1:0]   req_block;
  logic                   req_wb_ok;
  logic                   req_fl_ok;
  logic [TrackBits-1:0]   req_track;
  logic [FillBits-1:0]    remain;

  // scan pipeline
  logic [CntW-1:0]        rd_cnt;
  logic                   rd_issue;
  logic                   pipe_vld;
  logic [IdxW-1:0]        pipe_idx;

  // ram and scan unit wiring
  logic [TrackBits-1:0]   track_rd;
  logic [StampBits-1:0]   stamp_rd;
  logic [StampBits-1:0]   stamp_eff;
  logic                   track_we;
  logic                   stamp_we;
  scan_ctl_t              scan_ctl;
  scan_flags_t            scan_flags;
  logic [IdxW-1:0]        hit_idx;
  logic [IdxW-1:0]        empty_idx;
  logic [IdxW-1:0]        min_idx;
  logic [TrackBits-1:0]   min_track;

  // decision
  logic                   beyond;
  logic [BlockBits-1:0]   diff;
  logic [IdxW-1:0]        target;
  logic                   evict;
  logic                   proceed;

  assign req_track           = req_block[BlockBits-1:SectorBits];
  assign access_counter_next = access_counter + 1'b1;
  assign busy                = (state != S_IDLE);
  assign cfg_ready           = (state == S_IDLE);
  assign rd_issue            = (state == S_SCAN) && (rd_cnt < SlotCnt);
  assign stamp_eff           = slot_fresh[pipe_idx] ? stamp_rd : '0;

  // image bound and fill length
  assign beyond = (req_block >= image_blocks);
  assign diff   = image_blocks - {req_track, SectorBits'(0)};

  // victim selection after the scan
  always_comb begin
    evict   = 1'b0;
    proceed = 1'b1;
    if (scan_flags.hit_found) begin
      target = hit_idx;
    end else if (scan_flags.empty_found) begin
      target = empty_idx;
    end else begin
      target  = min_idx;
      evict   = 1'b1;
      proceed = req_wb_ok;
    end
  end

  // ram write enables
  assign track_we = (state == S_DECIDE) && !scan_flags.hit_found && proceed && req_fl_ok;
  assign stamp_we = (state == S_DECIDE) && (scan_flags.hit_found || (proceed && req_fl_ok));

  assign scan_ctl.clear     = (state == S_CHECK);
  assign scan_ctl.entry_vld = pipe_vld;

  tcl_ram #(
    .WIDTH (TrackBits),
    .DEPTH (SLOTS)
  ) u_track_ram (
    .clk     (clk),
    .wr_en   (track_we),
    .wr_addr (target),
    .wr_data (req_track),
    .rd_en   (rd_issue),
    .rd_addr (rd_cnt[IdxW-1:0]),
    .rd_data (track_rd)
  );

  tcl_ram #(
    .WIDTH (StampBits),
    .DEPTH (SLOTS)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (stamp_we),
    .wr_addr (target),
    .wr_data (access_counter),
    .rd_en   (rd_issue),
    .rd_addr (rd_cnt[IdxW-1:0]),
    .rd_data (stamp_rd)
  );

  tcl_scan #(
    .IDX_W (IdxW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctl         (scan_ctl),
    .idx         (pipe_idx),
    .entry_valid (slot_valid[pipe_idx]),
    .entry_track (track_rd),
    .entry_stamp (stamp_eff),
    .req_track   (req_track),
    .flags       (scan_flags),
    .hit_idx     (hit_idx),
    .empty_idx   (empty_idx),
    .min_idx     (min_idx),
    .min_track   (min_track)
  );

  // sequencer, cache state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      image_blocks   <= BlockBits'(1);
      access_counter <= '0;
      slot_valid     <= '0;
      slot_fresh     <= '0;
      done           <= 1'b0;
      pipe_vld       <= 1'b0;
      rd_cnt         <= '0;
    end else begin
      done <= 1'b0;

      // configuration beat
      if (cfg_valid && cfg_ready) begin
        image_blocks <= cfg_data;
      end

      // read pipeline: entry data follows its address in the next cycle
      pipe_vld <= rd_issue;
      if (rd_issue) begin
        pipe_idx <= rd_cnt[IdxW-1:0];
        rd_cnt   <= rd_cnt + 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            req_block      <= block;
            req_wb_ok      <= writeback_ok;
            req_fl_ok      <= fill_ok;
            access_counter <= access_counter_next;
            // counter wrap clears every stamp
            if (access_counter_next == '0) begin
              slot_fresh <= '0;
            end
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          rd_cnt          <= '0;
          sector_in_track <= req_block[SectorBits-1:0];
          remain          <= (diff > TrackSectors) ? FillBits'(TrackSectors)
                                                   : diff[FillBits-1:0];
          if (beyond) begin
            status       <= ST_BEYOND;
            hit          <= 1'b0;
            slot         <= '0;
            writeback    <= 1'b0;
            victim_track <= '0;
            fill         <= 1'b0;
            fill_sectors <= '0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (pipe_vld && (pipe_idx == LastIdx)) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          slot         <= 4'(target);
          hit          <= scan_flags.hit_found;
          writeback    <= evict;
          victim_track <= evict ? min_track : '0;
          fill         <= !scan_flags.hit_found && proceed;
          fill_sectors <= (!scan_flags.hit_found && proceed) ? remain : '0;
          if (scan_flags.hit_found) begin
            status             <= ST_OK;
            slot_fresh[target] <= 1'b1;
          end else if (!proceed) begin
            status <= ST_WB_FAIL;
          end else if (req_fl_ok) begin
            status             <= ST_OK;
            slot_valid[target] <= 1'b1;
            slot_fresh[target] <= 1'b1;
          end else begin
            status             <= ST_FL_FAIL;
            slot_valid[target] <= 1'b0;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a result beat only follows the bound check or the decision step
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_DECIDE || $past(state) == S_CHECK)
    else $error("result beat without a finished request");

  // the result beat is shown while the block is ready again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && cfg_ready)
    else $error("result beat while busy");

  // out-of-image results carry no cache action
  a_beyond_clean: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_BEYOND |-> !hit && !fill && !writeback && slot == '0)
    else $error("cache action on a block beyond the image");

  // a hit never evicts or fills
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> !fill && !writeback && status == ST_OK)
    else $error("hit with eviction or fill");

  // a failed writeback blocks the fill
  a_wb_fail: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_WB_FAIL |-> writeback && !fill && fill_sectors == '0)
    else $error("fill after failed writeback");
`endif

endmodule

`default_nettype wire

/* hw/rtl/tcl_ram.sv */
// ----------------------------------------------------------------------------
// tcl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No reset on the storage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcl_scan.sv */
// ----------------------------------------------------------------------------
// tcl_scan
// Slot scan unit. Takes one slot entry per cycle and keeps the first hit,
// the first empty slot and the first slot with the smallest stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_scan #(
  parameter int unsigned IDX_W = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tcl_pkg::scan_ctl_t                 ctl,
  input  wire logic [IDX_W-1:0]                   idx,
  input  wire logic                               entry_valid,
  input  wire logic [tcl_pkg::TrackBits-1:0]      entry_track,
  input  wire logic [tcl_pkg::StampBits-1:0]      entry_stamp,
  input  wire logic [tcl_pkg::TrackBits-1:0]      req_track,
  output tcl_pkg::scan_flags_t                    flags,
  output logic      [IDX_W-1:0]                   hit_idx,
  output logic      [IDX_W-1:0]                   empty_idx,
  output logic      [IDX_W-1:0]                   min_idx,
  output logic      [tcl_pkg::TrackBits-1:0]      min_track
);

  import tcl_pkg::*;

  logic                 have_min;
  logic [StampBits-1:0] min_stamp;
  logic                 match;
  logic                 lower;

  // the one compare unit: track equality and stamp ordering
  assign match = entry_valid && (entry_track == req_track);
  assign lower = !have_min || (entry_stamp < min_stamp);

  // running hit, empty and minimum search
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      flags    <= '0;
      have_min <= 1'b0;
    end else if (ctl.entry_vld) begin
      if (!flags.hit_found && match) begin
        flags.hit_found <= 1'b1;
        hit_idx         <= idx;
      end
      if (!flags.empty_found && !entry_valid) begin
        flags.empty_found <= 1'b1;
        empty_idx         <= idx;
      end
      if (lower) begin
        have_min  <= 1'b1;
        min_stamp <= entry_stamp;
        min_idx   <= idx;
        min_track <= entry_track;
      end
    end
  end

`ifndef ASSERT_OFF
  // a hit, once found, stays set with the same index until the next scan starts
  a_hit_sticky: assert property (@(posedge clk) disable iff (rst)
    flags.hit_found && !ctl.clear |=> flags.hit_found && $stable(hit_idx))
    else $error("hit result changed within a scan");

  // the minimum is established once any entry has been compared
  a_min_seen: assert property (@(posedge clk) disable iff (rst)
    ctl.entry_vld && !ctl.clear |=> have_min)
    else $error("no minimum after an entry was compared");

  // empty flag only set from an entry with its valid bit low
  a_empty_src: assert property (@(posedge clk) disable iff (rst)
    $rose(flags.empty_found) |-> $past(ctl.entry_vld) && !$past(entry_valid))
    else $error("empty slot flagged without an empty entry");
`endif

endmodule

`default_nettype wire

/* tb/sv/track_cache_lru_lookup_checker.sv */
// ----------------------------------------------------------------------------
// track_cache_lru_lookup_checker
// Watches the request, result and config channels of the track cache lookup
// block. Keeps its own copy of the slot table, stamps and access counter,
// predicts one result per accepted request and compares the result beats
// field by field, in order, against the predictions.
// ----------------------------------------------------------------------------
module track_cache_lru_lookup_checker
  import tcl_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // request
  input  logic                      start,
  input  logic                      busy,
  input  logic [BlockBits-1:0]      block,
  input  logic                      writeback_ok,
  input  logic                      fill_ok,
  // result
  input  logic                      done,
  input  logic [1:0]                status,
  input  logic                      hit,
  input  logic [3:0]                slot,
  input  logic [SectorBits-1:0]     sector_in_track,
  input  logic                      writeback,
  input  logic [TrackBits-1:0]      victim_track,
  input  logic                      fill,
  input  logic [FillBits-1:0]       fill_sectors,
  // configuration
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [BlockBits-1:0]      cfg_data,
  // to the testbench top
  output int                        mismatch_count,
  output int                        lookups_outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t               status;
    logic                  hit;
    logic [3:0]            slot;
    logic [SectorBits-1:0] sector;
    logic                  writeback;
    logic [TrackBits-1:0]  victim;
    logic                  fill;
    logic [FillBits-1:0]   fill_sectors;
  } lookup_result_t;

  // shadow of the cache state
  logic [BlockBits-1:0] image_size;
  logic                 entry_valid [NUM_SLOTS];
  logic [TrackBits-1:0] entry_track [NUM_SLOTS];
  logic [StampBits-1:0] entry_stamp [NUM_SLOTS];
  logic [StampBits-1:0] access_count;

  lookup_result_t expected_lookups [$];

  initial begin
    mismatch_count = 0;
    lookups_outstanding = 0;
  end

  // predict the result of one request and update the shadow state
  function automatic lookup_result_t lookup_track(input logic [BlockBits-1:0] blk,
                                                  input logic wb_ok, input logic fl_ok);
    lookup_result_t       r;
    logic [TrackBits-1:0] trk;
    logic [BlockBits:0]   remain;
    logic [StampBits-1:0] oldest;
    int                   target;
    bit                   found;
    r = '0;
    r.status = ST_OK;
    trk = blk[BlockBits-1:SectorBits];
    r.sector = blk[SectorBits-1:0];
    target = 0;
    found = 1'b0;

    // counter wrap clears every stamp
    access_count = access_count + 1;
    if (access_count == '0) begin
      for (int i = 0; i < NUM_SLOTS; i++) entry_stamp[i] = '0;
    end

    if (blk >= image_size) begin
      r.status = ST_BEYOND;
      return r;
    end

    // sectors left in this track, capped at a full track
    remain = {1'b0, image_size} - {1'b0, trk, 8'h00};
    if (remain > {1'b0, TrackSectors}) remain = {1'b0, TrackSectors};

    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && entry_valid[i] && entry_track[i] == trk) begin
        found = 1'b1;
        target = i;
      end
    end

    if (found) begin
      entry_stamp[target] = access_count;
      r.hit = 1'b1;
      r.slot = target[3:0];
      return r;
    end

    // miss: lowest empty slot first
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && !entry_valid[i]) begin
        found = 1'b1;
        target = i;
      end
    end

    // no empty slot: oldest stamp, lowest index on ties
    if (!found) begin
      oldest = entry_stamp[0];
      target = 0;
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if (entry_stamp[i] < oldest) begin
          oldest = entry_stamp[i];
          target = i;
        end
      end
      r.writeback = 1'b1;
      r.victim = entry_track[target];
      if (!wb_ok) r.status = ST_WB_FAIL;
      else entry_valid[target] = 1'b0;
    end

    r.slot = target[3:0];
    if (r.status != ST_WB_FAIL) begin
      r.fill = 1'b1;
      r.fill_sectors = remain[FillBits-1:0];
      if (fl_ok) begin
        entry_valid[target] = 1'b1;
        entry_track[target] = trk;
        entry_stamp[target] = access_count;
      end else begin
        r.status = ST_FL_FAIL;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // channel monitor, all sampling on the rising edge
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      image_size = 32'd1;
      access_count = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        entry_valid[i] = 1'b0;
        entry_track[i] = '0;
        entry_stamp[i] = '0;
      end
      expected_lookups.delete();
    end else begin
      // result beat
      if (done) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d slot %0d",
                   $time, status, slot);
          mismatch_count++;
        end else begin
          want = expected_lookups.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("slot", 32'(want.slot), 32'(slot));
          check_field("sector_in_track", 32'(want.sector), 32'(sector_in_track));
          check_field("writeback", 32'(want.writeback), 32'(writeback));
          check_field("victim_track", 32'(want.victim), 32'(victim_track));
          check_field("fill", 32'(want.fill), 32'(fill));
          check_field("fill_sectors", 32'(want.fill_sectors), 32'(fill_sectors));
        end
      end
      // config beat
      if (cfg_valid && cfg_ready) image_size = cfg_data;
      // request beat
      if (start && !busy) expected_lookups.push_back(lookup_track(block, writeback_ok, fill_ok));
    end
    lookups_outstanding = expected_lookups.size();
  end

endmodule

/* tb/sv/track_cache_lru_lookup_tb.sv */
// ----------------------------------------------------------------------------
// track_cache_lru_lookup_tb
// Drives requests and image size writes into the track cache lookup block:
// a directed pass over hits, fills, evictions, failed writebacks and fills,
// partial last tracks and blocks beyond the image, then random phases with a
// small working set of tracks per image size. The checker scores results.
// ----------------------------------------------------------------------------
module track_cache_lru_lookup_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tcl_pkg::*;

  localparam int unsigned NumSlots   = 16;
  localparam int          StallLimit = 2000;
  localparam int          NumPhases  = 6;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [BlockBits-1:0]  block;
  logic                  writeback_ok;
  logic                  fill_ok;
  logic                  done;
  logic [1:0]            status;
  logic                  hit;
  logic [3:0]            slot;
  logic [SectorBits-1:0] sector_in_track;
  logic                  writeback;
  logic [TrackBits-1:0]  victim_track;
  logic                  fill;
  logic [FillBits-1:0]   fill_sectors;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [BlockBits-1:0]  cfg_data;

  int mismatch_count;
  int lookups_outstanding;
  int quiet_cycles;

  track_cache_lru_lookup #(
    .SLOTS(NumSlots)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .block(block),
    .writeback_ok(writeback_ok),
    .fill_ok(fill_ok),
    .done(done),
    .status(status),
    .hit(hit),
    .slot(slot),
    .sector_in_track(sector_in_track),
    .writeback(writeback),
    .victim_track(victim_track),
    .fill(fill),
    .fill_sectors(fill_sectors),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  track_cache_lru_lookup_checker #(
    .NUM_SLOTS(NumSlots)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .block(block),
    .writeback_ok(writeback_ok),
    .fill_ok(fill_ok),
    .done(done),
    .status(status),
    .hit(hit),
    .slot(slot),
    .sector_in_track(sector_in_track),
    .writeback(writeback),
    .victim_track(victim_track),
    .fill(fill),
    .fill_sectors(fill_sectors),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .lookups_outstanding(lookups_outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request beat; entered and left on a falling edge, start left high
  task automatic send_request(input logic [BlockBits-1:0] blk, input logic wb_ok,
                              input logic fl_ok, input int gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    block <= blk;
    writeback_ok <= wb_ok;
    fill_ok <= fl_ok;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // image size write once every lookup has come back
  task automatic write_image_blocks(input logic [BlockBits-1:0] value);
    start <= 1'b0;
    while (lookups_outstanding != 0 || busy) @(negedge clk);
    repeat ($urandom_range(0, 12)) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [BlockBits-1:0] image;
    logic [BlockBits-1:0] blk;
    logic [TrackBits-1:0] max_track;
    logic [TrackBits-1:0] track_pool [$];
    logic [TrackBits-1:0] trk;
    logic [7:0]           sec;
    int                   pool_size;
    int                   phase_items;
    int                   roll;
    bit                   burst;

    rst = 1'b1;
    quiet_cycles = 0;
    start = 1'b0;
    block = '0;
    writeback_ok = 1'b0;
    fill_ok = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one-sector image after reset: fill, hit, beyond the image
    send_request(32'h0000_0000, 1'b1, 1'b1, $urandom_range(0, 12));
    send_request(32'h0000_0000, 1'b1, 1'b1, $urandom_range(0, 12));
    send_request(32'hFFFF_FFFF, 1'b1, 1'b1, $urandom_range(0, 12));

    // largest image: last track is one sector short
    write_image_blocks(32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFE, 1'b1, 1'b1, $urandom_range(0, 12));
    send_request(32'hFFFF_FFFF, 1'b0, 1'b0, $urandom_range(0, 12));
    for (int t = 1; t <= 14; t++) begin
      send_request({t[TrackBits-1:0], 8'hA5}, 1'b1, 1'b1, $urandom_range(0, 12));
    end

    // cache full: failed writeback, failed fill after eviction, refill empty slot
    send_request(32'h0001_0000, 1'b0, 1'b1, $urandom_range(0, 12));
    send_request(32'h0002_0011, 1'b1, 1'b0, $urandom_range(0, 12));
    send_request(32'h0003_00FF, 1'b1, 1'b1, $urandom_range(0, 12));

    // partial last track with eviction
    write_image_blocks(32'h0000_1234);
    send_request(32'h0000_1200, 1'b1, 1'b1, $urandom_range(0, 12));

    // random phases, each with its own image size and working set
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: image = 32'hFFFF_FFFF;
        1: image = $urandom_range(1, 8191);
        2: image = 32'd1;
        3: image = {16'h0000, 8'($urandom_range(1, 64)), 8'h00};
        default: image = $urandom;
      endcase
      if (image == '0) image = 32'd1;
      write_image_blocks(image);

      max_track = 24'((image - 1) >> SectorBits);
      pool_size = $urandom_range(4, 40);
      track_pool.delete();
      for (int i = 0; i < pool_size; i++) begin
        if ($urandom_range(0, 7) == 0) track_pool.push_back(max_track);
        else track_pool.push_back(24'($urandom_range(0, 32'(max_track))));
      end
      burst = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(130, 170);

      for (int n = 0; n < phase_items; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // arbitrary block
          blk = $urandom;
        end else if (roll < 12) begin
          // at or past the end of the image
          blk = image + $urandom_range(0, ~image);
        end else begin
          trk = track_pool[$urandom_range(0, pool_size - 1)];
          sec = 8'($urandom_range(0, 255));
          blk = {trk, sec};
          if (blk >= image) blk = image - 1;
        end
        send_request(blk, ($urandom_range(0, 99) < 85), ($urandom_range(0, 99) < 88),
                     burst ? 0 : $urandom_range(0, 12));
      end
    end

    // drain
    start <= 1'b0;
    while (lookups_outstanding != 0) @(negedge clk);
    repeat (NumSlots * 2 + 8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tcl_pkg.sv
hw/rtl/tcl_ram.sv
hw/rtl/tcl_scan.sv
hw/rtl/track_cache_lru_lookup.sv
tb/sv/track_cache_lru_lookup_checker.sv
tb/sv/track_cache_lru_lookup_tb.sv
